FILE: design/dta_pkg.sv
// shared constants, types and state codes for the drainage tree accumulator
`default_nettype none
package dta_pkg;
    localparam int NODES = 64;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);
    localparam int VAL_W = 32;
    localparam int CFG_W = 7;

    // register indexes
    localparam logic CFG_NODE_COUNT   = 1'b0;
    localparam logic CFG_COMBINE_MODE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_CYCLE    = 2'd2;
    localparam logic [1:0] ST_NEGATIVE = 2'd3;

    typedef enum logic [4:0] {
        S_LOAD, S_CLR, S_DRD, S_DCK, S_DWR, S_SRD, S_SCK,
        S_QRD, S_KDS, S_KDG, S_KWR, S_CHK,
        S_ARD, S_AFE, S_ASUM, S_AWR,
        S_ORD, S_OLD, S_OWT, S_ERR
    } t_state;
endpackage
`default_nettype wire

FILE: design/dta_in_if.sv
// input channel carrying one node word
`default_nettype none
interface dta_in_if import dta_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] node_index;
    logic             has_downstream;
    logic [IDX_W-1:0] downstream_index;
    logic signed [VAL_W-1:0] local_value;
    logic             load_last;
    modport source (output valid, node_index, has_downstream, downstream_index,
                    local_value, load_last, input ready);
    modport sink (input valid, node_index, has_downstream, downstream_index,
                  local_value, load_last, output ready);
endinterface
`default_nettype wire

FILE: design/dta_out_if.sv
// output channel carrying one result word
`default_nettype none
interface dta_out_if import dta_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] out_index;
    logic [VAL_W-1:0] total_value;
    logic [1:0]       status;
    logic             out_last;
    modport source (output valid, out_index, total_value, status, out_last,
                    input ready);
    modport sink (input valid, out_index, total_value, status, out_last,
                  output ready);
endinterface
`default_nettype wire

FILE: design/dta_alu.sv
// shared saturating adder and max unit
`default_nettype none
module dta_alu import dta_pkg::*; (
    input  wire logic [VAL_W-1:0] i_a,
    input  wire logic [VAL_W-1:0] i_b,
    input  wire logic             i_max,
    output logic      [VAL_W-1:0] o_y
);
    logic [VAL_W:0] sum;

    // one wide add; carry out saturates, compare reuses the same operands
    always_comb begin
        sum = {1'b0, i_a} + {1'b0, i_b};
        if (i_max) begin
            o_y = (i_a > i_b) ? i_a : i_b;
        end else begin
            o_y = sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
        end
    end
endmodule
`default_nettype wire

FILE: design/drainage_tree_accumulator_core.sv
// Top level: node loader, Kahn ordering sequencer and flow accumulation.
// Loading takes one node word per cycle. After the last word: clear in-degrees and
// inflows, count in-degrees, seed the queue, order the nodes, accumulate flow, send
// one result word per node or one error word (one shared adder, one read port per
// table). Sync active-low reset clears the sequencer and output valid; node tables
// are not cleared and in-degree/inflow tables are swept per job.
`default_nettype none
module drainage_tree_accumulator_core import dta_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dta_in_if.sink           i_in,
    dta_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [CFG_W-1:0] r_node_count;
    logic             r_mode;
    logic [CNT_W-1:0] r_i, r_head, r_tail;
    logic [IDX_W-1:0] r_cur, r_d;
    logic             r_neg;
    logic [VAL_W-1:0] r_tot;
    logic             r_ov, r_olast;
    logic [IDX_W-1:0] r_oidx;
    logic [VAL_W-1:0] r_oval;
    logic [1:0]       r_ostat;
    logic [1:0]       r_err;

    // memories
    logic [IDX_W:0]   ds_mem  [NODES];
    logic [VAL_W-1:0] loc_mem [NODES];
    logic [CNT_W-1:0] deg_mem [NODES];
    logic [VAL_W-1:0] inf_mem [NODES];
    logic [IDX_W-1:0] q_mem   [NODES];

    logic [IDX_W:0]   ds_rd;
    logic [VAL_W-1:0] loc_rd, inf_rd;
    logic [CNT_W-1:0] deg_rd;
    logic [IDX_W-1:0] q_rd;

    logic [IDX_W-1:0] ds_ra, loc_ra, deg_ra, inf_ra, q_ra;
    logic [IDX_W-1:0] deg_wa, inf_wa;
    logic [CNT_W-1:0] deg_wd;
    logic [VAL_W-1:0] inf_wd;
    logic             deg_we, inf_we, q_we;

    logic [CNT_W-1:0] n_cnt;
    logic             i_end;
    logic             ds_v;
    logic [IDX_W-1:0] ds_d;
    logic [VAL_W-1:0] loc_pos;
    logic [VAL_W-1:0] alu_a, alu_b, alu_y;
    logic             alu_max;
    logic             in_acc, out_acc;

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = r_ov & o_out.ready;
    assign ds_v    = ds_rd[IDX_W];
    assign ds_d    = ds_rd[IDX_W-1:0];
    assign loc_pos = loc_rd[VAL_W-1] ? '0 : loc_rd;

    // node count clamped to 1..NODES
    always_comb begin
        if (r_node_count == '0) begin
            n_cnt = CNT_W'(1);
        end else if (r_node_count > CFG_W'(NODES)) begin
            n_cnt = CNT_W'(NODES);
        end else begin
            n_cnt = CNT_W'(r_node_count);
        end
    end
    assign i_end = (r_i == n_cnt - CNT_W'(1));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(1);
            r_mode       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT:   r_node_count <= i_cfg_data;
                CFG_COMBINE_MODE: r_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // node tables written by the loader
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            ds_mem[i_in.node_index] <= {i_in.has_downstream &&
                (i_in.downstream_index != i_in.node_index), i_in.downstream_index};
            loc_mem[i_in.node_index] <= i_in.local_value;
        end
        ds_rd  <= ds_mem[ds_ra];
        loc_rd <= loc_mem[loc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) deg_mem[deg_wa] <= deg_wd;
        deg_rd <= deg_mem[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (inf_we) inf_mem[inf_wa] <= inf_wd;
        inf_rd <= inf_mem[inf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) q_mem[r_tail[IDX_W-1:0]] <= r_d;
        q_rd <= q_mem[q_ra];
    end

    dta_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_max (alu_max),
        .o_y   (alu_y)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (in_acc && i_in.load_last) n_state = S_CLR;
            S_CLR:  if (i_end) n_state = S_DRD;
            S_DRD:  n_state = S_DCK;
            S_DCK: begin
                if (ds_v && (CNT_W'(ds_d) >= n_cnt)) n_state = S_ERR;
                else if (ds_v) n_state = S_DWR;
                else if (i_end) n_state = S_SRD;
                else n_state = S_DRD;
            end
            S_DWR:  n_state = i_end ? S_SRD : S_DRD;
            S_SRD:  n_state = S_SCK;
            S_SCK:  n_state = i_end ? S_QRD : S_SRD;
            S_QRD:  n_state = (r_head == r_tail) ? S_CHK : S_KDS;
            S_KDS:  n_state = S_KDG;
            S_KDG:  n_state = ds_v ? S_KWR : S_QRD;
            S_KWR:  n_state = S_QRD;
            S_CHK: begin
                if (r_tail != n_cnt || (r_mode && r_neg)) n_state = S_ERR;
                else n_state = S_ARD;
            end
            S_ARD:  n_state = (r_head == r_tail) ? S_ORD : S_AFE;
            S_AFE:  n_state = S_ASUM;
            S_ASUM: n_state = ds_v ? S_AWR : S_ARD;
            S_AWR:  n_state = S_ARD;
            S_ORD:  n_state = S_OLD;
            S_OLD:  n_state = S_OWT;
            S_OWT: begin
                if (out_acc) n_state = r_olast ? S_LOAD : S_ORD;
            end
            S_ERR:  n_state = S_OWT;
            default: n_state = S_LOAD;
        endcase
    end

    // memory controls and shared unit operands
    always_comb begin
        ds_ra   = r_i[IDX_W-1:0];
        loc_ra  = r_i[IDX_W-1:0];
        deg_ra  = r_i[IDX_W-1:0];
        inf_ra  = r_i[IDX_W-1:0];
        q_ra    = r_head[IDX_W-1:0];
        deg_we  = 1'b0;
        deg_wa  = r_i[IDX_W-1:0];
        deg_wd  = '0;
        inf_we  = 1'b0;
        inf_wa  = r_i[IDX_W-1:0];
        inf_wd  = '0;
        q_we    = 1'b0;
        alu_a   = inf_rd;
        alu_b   = loc_pos;
        alu_max = 1'b0;
        unique case (r_state)
            S_CLR: begin
                deg_we = 1'b1;
                inf_we = 1'b1;
            end
            S_DCK: deg_ra = ds_d;
            S_DWR: begin
                deg_we = 1'b1;
                deg_wa = r_d;
                deg_wd = deg_rd + CNT_W'(1);
            end
            S_SCK: q_we = (deg_rd == '0);
            S_KDS: ds_ra = q_rd;
            S_KDG: deg_ra = ds_d;
            S_KWR: begin
                deg_we = (deg_rd != '0);
                deg_wa = r_d;
                deg_wd = deg_rd - CNT_W'(1);
                q_we   = (deg_rd == CNT_W'(1)) && (r_tail < CNT_W'(NODES));
            end
            S_AFE: begin
                ds_ra  = q_rd;
                loc_ra = q_rd;
                inf_ra = q_rd;
            end
            S_ASUM: begin
                inf_we = 1'b1;
                inf_wa = r_cur;
                inf_wd = alu_y;
                inf_ra = ds_d;
            end
            S_AWR: begin
                alu_a   = inf_rd;
                alu_b   = r_tot;
                alu_max = r_mode;
                inf_we  = 1'b1;
                inf_wa  = r_d;
                inf_wd  = alu_y;
            end
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_i     <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_neg   <= 1'b0;
            r_ov    <= 1'b0;
            r_olast <= 1'b0;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    r_i    <= '0;
                    r_head <= '0;
                    r_tail <= '0;
                    r_neg  <= 1'b0;
                end
                S_CLR: r_i <= i_end ? '0 : r_i + CNT_W'(1);
                S_DCK: begin
                    if (loc_rd[VAL_W-1]) r_neg <= 1'b1;
                    r_d <= ds_d;
                    if (ds_v && (CNT_W'(ds_d) >= n_cnt)) r_err <= ST_UNKNOWN;
                    else if (!ds_v) r_i <= i_end ? '0 : r_i + CNT_W'(1);
                end
                S_DWR: r_i <= i_end ? '0 : r_i + CNT_W'(1);
                S_SRD: r_d <= r_i[IDX_W-1:0];
                S_SCK: begin
                    if (deg_rd == '0) r_tail <= r_tail + CNT_W'(1);
                    r_i <= i_end ? '0 : r_i + CNT_W'(1);
                end
                S_QRD: if (r_head != r_tail) r_head <= r_head + CNT_W'(1);
                S_KDG: r_d <= ds_d;
                S_KWR: begin
                    if ((deg_rd == CNT_W'(1)) && (r_tail < CNT_W'(NODES)))
                        r_tail <= r_tail + CNT_W'(1);
                end
                S_CHK: begin
                    r_head <= '0;
                    if (r_tail != n_cnt) r_err <= ST_CYCLE;
                    else r_err <= ST_NEGATIVE;
                end
                S_ARD: begin
                    r_i <= '0;
                    if (r_head != r_tail) r_head <= r_head + CNT_W'(1);
                end
                S_AFE: r_cur <= q_rd;
                S_ASUM: begin
                    r_tot <= alu_y;
                    r_d   <= ds_d;
                end
                S_OLD: begin
                    r_ov    <= 1'b1;
                    r_oidx  <= r_i[IDX_W-1:0];
                    r_oval  <= inf_rd;
                    r_ostat <= ST_OK;
                    r_olast <= i_end;
                end
                S_OWT: begin
                    if (out_acc) begin
                        r_ov <= 1'b0;
                        r_i  <= r_i + CNT_W'(1);
                    end
                end
                S_ERR: begin
                    r_ov    <= 1'b1;
                    r_oidx  <= '0;
                    r_oval  <= '0;
                    r_ostat <= r_err;
                    r_olast <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // port drive
    assign i_in.ready        = (r_state == S_LOAD);
    assign o_out.valid       = r_ov;
    assign o_out.out_index   = r_oidx;
    assign o_out.total_value = r_oval;
    assign o_out.status      = r_ostat;
    assign o_out.out_last    = r_olast;

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("input taken while result pending");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail <= CNT_W'(NODES)) && (r_head <= r_tail)) else $error("queue pointers out of range");
    a_job_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_olast) |=> (r_state == S_LOAD)) else $error("no return to loading");
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> o_out.out_last)
        else $error("error word not last");
endmodule
`default_nettype wire

FILE: dv/drainage_tree_accumulator_core_tb.sv
// self-checking testbench for the drainage tree accumulator core
`default_nettype none
module drainage_tree_accumulator_core_tb;
    import dta_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             has;
        logic [IDX_W-1:0] ds;
        logic [VAL_W-1:0] val;
        logic             last;
    } node_word_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] total;
        logic [1:0]       status;
        logic             last;
    } total_word_t;

    localparam int JOB_OK    = 0;
    localparam int JOB_UNK   = 1;
    localparam int JOB_CYCLE = 2;
    localparam int JOB_NEG   = 3;
    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    dta_in_if  in_ch ();
    dta_out_if out_ch ();

    drainage_tree_accumulator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // node words waiting to be sent and totals waiting to arrive
    node_word_t  load_q[$];
    total_word_t totals_q[$];

    // shadow of the block's node tables and registers
    logic [IDX_W-1:0] ds_tab [NODES];
    logic             ds_vld [NODES];
    logic [VAL_W-1:0] loc_tab [NODES];
    int               cfg_nodes;
    logic             cfg_max;

    int  in_idle_pct;
    int  out_idle_pct;
    int  fail_cnt;
    int  jobs_sent;
    int  words_checked;
    int  err_words;
    int  stall_cnt;
    bit  done;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? '1 : s[VAL_W-1:0];
    endfunction

    // topological flow accumulation over the shadow tables
    task automatic predict_totals();
        int n, head, tail, cur, d;
        int deg [NODES];
        int order [NODES];
        logic [VAL_W-1:0] flow [NODES];
        logic [VAL_W-1:0] loc, tot;
        logic [1:0] err;
        total_word_t w;
        n = cfg_nodes < 1 ? 1 : (cfg_nodes > NODES ? NODES : cfg_nodes);
        err = ST_OK;
        for (int i = 0; i < NODES; i++) begin
            deg[i] = 0;
            flow[i] = '0;
        end
        for (int i = 0; i < n; i++) begin
            if (err == ST_OK && ds_vld[i]) begin
                if (ds_tab[i] >= n) err = ST_UNKNOWN;
                else deg[ds_tab[i]]++;
            end
        end
        if (err == ST_OK) begin
            tail = 0;
            for (int i = 0; i < n; i++)
                if (deg[i] == 0) order[tail++] = i;
            head = 0;
            while (head < tail) begin
                cur = order[head++];
                if (ds_vld[cur]) begin
                    d = ds_tab[cur];
                    if (deg[d] > 0) begin
                        deg[d]--;
                        if (deg[d] == 0) order[tail++] = d;
                    end
                end
            end
            if (tail != n) err = ST_CYCLE;
        end
        if (err == ST_OK && cfg_max) begin
            for (int i = 0; i < n; i++)
                if (loc_tab[i][VAL_W-1]) err = ST_NEGATIVE;
        end
        if (err != ST_OK) begin
            w = '{idx: '0, total: '0, status: err, last: 1'b1};
            totals_q.push_back(w);
            err_words++;
        end else begin
            for (int k = 0; k < n; k++) begin
                cur = order[k];
                loc = loc_tab[cur][VAL_W-1] ? '0 : loc_tab[cur];
                tot = sat_add(flow[cur], loc);
                flow[cur] = tot;
                if (ds_vld[cur]) begin
                    d = ds_tab[cur];
                    if (cfg_max) begin
                        if (tot > flow[d]) flow[d] = tot;
                    end else begin
                        flow[d] = sat_add(flow[d], tot);
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                w = '{idx: i[IDX_W-1:0], total: flow[i], status: ST_OK, last: (i == n - 1)};
                totals_q.push_back(w);
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (load_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                node_word_t w;
                w = load_q.pop_front();
                in_ch.valid            <= 1'b1;
                in_ch.node_index       <= w.idx;
                in_ch.has_downstream   <= w.has;
                in_ch.downstream_index <= w.ds;
                in_ch.local_value      <= w.val;
                in_ch.load_last        <= w.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // accepted node words update the shadow tables
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            ds_vld[in_ch.node_index]  = in_ch.has_downstream &&
                                        (in_ch.downstream_index != in_ch.node_index);
            ds_tab[in_ch.node_index]  = in_ch.downstream_index;
            loc_tab[in_ch.node_index] = in_ch.local_value;
            if (in_ch.load_last) predict_totals();
        end
    end

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            total_word_t e;
            if (totals_q.size() == 0) begin
                $error("unexpected word: index %0d total %h status %0d",
                       out_ch.out_index, out_ch.total_value, out_ch.status);
                fail_cnt++;
            end else begin
                e = totals_q.pop_front();
                words_checked++;
                if (out_ch.out_index !== e.idx) begin
                    $error("out_index: expected %0d actual %0d", e.idx, out_ch.out_index);
                    fail_cnt++;
                end
                if (out_ch.total_value !== e.total) begin
                    $error("total_value: expected %h actual %h", e.total, out_ch.total_value);
                    fail_cnt++;
                end
                if (out_ch.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, out_ch.status);
                    fail_cnt++;
                end
                if (out_ch.out_last !== e.last) begin
                    $error("out_last: expected %0d actual %0d", e.last, out_ch.out_last);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || done || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic cfg_write(logic idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_NODE_COUNT) cfg_nodes = int'(data);
        else cfg_max = data[0];
    endtask

    // block until every word is sent and every total has come back
    task automatic drain();
        wait (load_q.size() == 0 && !in_ch.valid && totals_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(bit nonneg);
        logic [VAL_W-1:0] v;
        case ($urandom_range(7))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h0000_0000;
            2: v = 32'hFFFF_FFFF;
            3: v = $urandom_range(32'h0010_0000);
            default: v = $urandom;
        endcase
        if (nonneg) v[VAL_W-1] = 1'b0;
        return v;
    endfunction

    // one job: every node 0..n-1 written once, in random order, last word starts it
    task automatic queue_job(int n, int kind, bit noise);
        int rank [NODES];
        int slot [NODES];
        int a, b, j, t;
        node_word_t w [NODES];
        node_word_t nz;
        for (int i = 0; i < n; i++) rank[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = rank[i]; rank[i] = rank[j]; rank[j] = t;
        end
        // downstream points to a later rank or to the node itself, which counts as none, so the tree is acyclic
        for (int k = 0; k < n; k++) begin
            a = rank[k];
            w[a].idx = IDX_W'(a);
            w[a].ds  = IDX_W'($urandom);
            w[a].has = 1'b0;
            if (k < n - 1 && $urandom_range(9) < 8) begin
                w[a].has = 1'b1;
                w[a].ds  = IDX_W'(rank[$urandom_range(n - 1, k + 1)]);
            end else if ($urandom_range(3) == 0) begin
                w[a].has = 1'b1;
                w[a].ds  = IDX_W'(a);
            end
            w[a].val  = pick_value(cfg_max);
            w[a].last = 1'b0;
        end
        if (kind == JOB_UNK && n < NODES) begin
            a = $urandom_range(n - 1);
            w[a].has = 1'b1;
            w[a].ds  = IDX_W'($urandom_range(NODES - 1, n));
        end else if (kind == JOB_CYCLE && n >= 2) begin
            a = rank[$urandom_range(n - 2)];
            b = rank[n - 1];
            w[a].has = 1'b1; w[a].ds = IDX_W'(b);
            w[b].has = 1'b1; w[b].ds = IDX_W'(a);
        end else if (kind == JOB_NEG) begin
            a = $urandom_range(n - 1);
            w[a].val = $urandom | 32'h8000_0000;
        end
        for (int i = 0; i < n; i++) slot[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = slot[i]; slot[i] = slot[j]; slot[j] = t;
        end
        w[slot[n - 1]].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            // words above the node count are stored but ignored by this job
            if (noise && n < NODES && i == n - 1) begin
                nz.idx = IDX_W'($urandom_range(NODES - 1, n));
                nz.has = 1'($urandom); nz.ds = IDX_W'($urandom); nz.val = $urandom;
                nz.last = 1'b0;
                load_q.push_back(nz);
            end
            load_q.push_back(w[slot[i]]);
        end
        jobs_sent++;
    endtask

    task automatic pick_kind(output int kind);
        int r;
        r = $urandom_range(99);
        kind = r < 70 ? JOB_OK : (r < 80 ? JOB_UNK : (r < 90 ? JOB_CYCLE : JOB_NEG));
    endtask

    // stimulus sequence
    initial begin
        int kind, n, words;
        fail_cnt = 0; jobs_sent = 0; words_checked = 0; err_words = 0;
        done = 1'b0; stall_cnt = 0;
        in_idle_pct = 37; out_idle_pct = 37;
        cfg_nodes = 1; cfg_max = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = CFG_NODE_COUNT; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.node_index = '0; in_ch.has_downstream = 1'b0;
        in_ch.downstream_index = '0; in_ch.local_value = '0; in_ch.load_last = 1'b0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single node in both modes, then small trees with each error
        cfg_write(CFG_NODE_COUNT, 7'd1);
        cfg_write(CFG_COMBINE_MODE, 7'd0);
        load_q.push_back('{idx: '0, has: 1'b1, ds: '0, val: 32'h7FFF_FFFF, last: 1'b1});
        load_q.push_back('{idx: '0, has: 1'b0, ds: '1, val: 32'h8000_0000, last: 1'b1});
        drain();
        cfg_write(CFG_COMBINE_MODE, 7'd1);
        load_q.push_back('{idx: '0, has: 1'b0, ds: '0, val: 32'hFFFF_FFFF, last: 1'b1});
        load_q.push_back('{idx: '0, has: 1'b0, ds: '0, val: 32'h0000_0000, last: 1'b1});
        drain();
        cfg_write(CFG_NODE_COUNT, 7'd4);
        cfg_write(CFG_COMBINE_MODE, 7'd0);
        // chain of large values saturates the sum
        for (int i = 0; i < 4; i++)
            load_q.push_back('{idx: IDX_W'(i), has: i < 3, ds: IDX_W'(i + 1),
                               val: 32'h7FFF_FFFF, last: i == 3});
        queue_job(4, JOB_UNK, 1'b0);
        queue_job(4, JOB_CYCLE, 1'b0);
        drain();
        cfg_write(CFG_COMBINE_MODE, 7'd1);
        queue_job(4, JOB_NEG, 1'b0);
        queue_job(4, JOB_OK, 1'b0);
        drain();

        // full-size network once in each mode, the second with no idling
        cfg_write(CFG_NODE_COUNT, 7'd64);
        queue_job(NODES, JOB_OK, 1'b0);
        drain();
        cfg_write(CFG_COMBINE_MODE, 7'd0);
        in_idle_pct = 0; out_idle_pct = 0;
        queue_job(NODES, JOB_OK, 1'b0);
        drain();
        in_idle_pct = 37; out_idle_pct = 37;

        // random small networks, mode and size changing between phases
        words = 0;
        while (words < 70) begin
            n = $urandom_range(2, 12);
            cfg_write(CFG_NODE_COUNT, n[CFG_W-1:0]);
            cfg_write(CFG_COMBINE_MODE, CFG_W'($urandom_range(1)));
            for (int j = 0; j < 3; j++) begin
                pick_kind(kind);
                queue_job(n, kind, 1'($urandom_range(1)));
                words += n + 1;
            end
            drain();
        end

        done = 1'b1;
        $display("jobs: %0d, total words checked: %0d (error words %0d)",
                 jobs_sent, words_checked, err_words);
        $display("covered sizes 1, 4, 2..12 and 64, both combine modes, all status codes");
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
